// ----- rtl/tick_task_dispatcher_top_defines.svh -----
// Assertion macros shared by the dispatcher RTL.
`ifndef TICK_TASK_DISPATCHER_TOP_DEFINES_SVH
`define TICK_TASK_DISPATCHER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define TSKD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every clock edge, including reset.
`define TSKD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSKD_ASSERT(lbl, clk, rstn, prop, msg)
`define TSKD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/tskd_pkg.sv -----
// Types and constants of the tick task dispatcher.
package tskd_pkg;

    localparam int SLOTS_DEF  = 8;
    localparam int SLOT_IDX_W = 5;
    localparam logic [15:0] WRAP_RESET = 16'd40000;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_BAD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_INVALID   = 3'd1,
        STS_DUP_ID    = 3'd2,
        STS_SLOT_USED = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_NO_LIVE   = 3'd5,
        STS_NONE_FIRE = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_DIV,
        S_FIRE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic        done;
        logic        periodic;
        logic [15:0] period;
        logic [7:0]  id;
    } entry_t;

    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] addr;
        entry_t                data;
    } mem_wr_t;

endpackage

// ----- rtl/tskd_mem.sv -----
// Task table memory: one write port, one registered read port.
module tskd_mem #(
    parameter int SLOTS = tskd_pkg::SLOTS_DEF
) (
    input  logic                            aclk,
    input  tskd_pkg::mem_wr_t               wr,
    input  logic                            rd_en,
    input  logic [tskd_pkg::SLOT_IDX_W-1:0] rd_addr,
    output tskd_pkg::entry_t                rd_data
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    tskd_pkg::entry_t mem [SLOTS];
    tskd_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- rtl/tskd_rem.sv -----
// Iterative remainder unit, two quotient bits per cycle over a 16-bit dividend.
module tskd_rem (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] num,
    input  logic [15:0] den,
    output logic        busy,
    output logic        done,
    output logic        rem_zero
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] num_reg, num_next;
    logic [15:0] den_reg, den_next;
    logic [16:0] r1, r1s, r2, r2s;

    always_comb begin
        r1  = {rem_reg[15:0], num_reg[15]};
        r1s = (r1 >= {1'b0, den_reg}) ? r1 - {1'b0, den_reg} : r1;
        r2  = {r1s[15:0], num_reg[14]};
        r2s = (r2 >= {1'b0, den_reg}) ? r2 - {1'b0, den_reg} : r2;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = r2s;
            num_next = {num_reg[13:0], 2'b00};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign rem_zero = (rem_reg == 17'd0);
endmodule

// ----- rtl/tick_task_dispatcher_top.sv -----
// Add and delete walk every table slot; a tick walks them too and runs a remainder per live slot.
// One request at a time: a new request is taken only once the slot walk of the
// last one is done and its response has been registered.
// Each table slot is first read from the table memory, then evaluated.
// Reset (aresetn low, synchronous) empties all slots, clears the tick count,
// loads wrap_limit with 40000 and drops all valid outputs.
`include "tick_task_dispatcher_top_defines.svh"
module tick_task_dispatcher_top #(
    parameter int SLOTS = tskd_pkg::SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // wrap_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // task_id[7:0], slot[10:8], period[26:11],
                                        // periodic[27], zero[31:28]
    input  logic [1:0]  s_tuser,        // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,        // fired_slot[2:0], fired_id[10:3], zero[15:11]
    output logic [3:0]  m_tuser,        // status[2:0], fired[3]
    output logic        m_tlast
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = tskd_pkg::SLOT_IDX_W;

    tskd_pkg::state_t state_reg, state_next;

    tskd_pkg::cmd_t cmd_reg, cmd_next;
    logic [7:0]  id_reg, id_next;
    logic [2:0]  slot_reg, slot_next;
    logic [15:0] period_reg, period_next;
    logic        periodic_reg, periodic_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        dup_reg, dup_next;
    logic        used_reg, used_next;
    logic        hit_reg, hit_next;
    logic        any_live_reg, any_live_next;
    logic        held_valid_reg, held_valid_next;
    logic [2:0]  held_slot_reg, held_slot_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [2:0]  cand_slot_reg, cand_slot_next;
    logic [7:0]  cand_id_reg, cand_id_next;
    tskd_pkg::entry_t ent_reg, ent_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] wrap_reg, wrap_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;
    logic [3:0]  m_user_reg, m_user_next;
    logic        m_last_reg, m_last_next;

    tskd_pkg::mem_wr_t wr;
    tskd_pkg::entry_t  rd_data;
    logic              rd_en;
    logic              rem_start, rem_busy, rem_done, rem_zero;

    logic          accept, out_free, last_slot, ev_live, ev_match, ev_div;
    logic [IW-1:0] idx_ext;
    logic [2:0]    idx_slot;
    logic          add_bad;

    tskd_mem #(.SLOTS(SLOTS)) u_mem (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (idx_ext),
        .rd_data (rd_data)
    );

    tskd_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .num      (cnt_reg),
        .den      (rd_data.period),
        .busy     (rem_busy),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    assign s_tready  = (state_reg == tskd_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign last_slot = (idx_reg == AW'(SLOTS - 1));
    assign idx_ext   = IW'(idx_reg);
    assign idx_slot  = idx_ext[2:0];
    assign ev_live   = valid_reg[idx_reg] && (rd_data.id != 8'd0) && !rd_data.done;
    assign ev_match  = ev_live && (rd_data.id == id_reg);
    assign ev_div    = (cmd_reg == tskd_pkg::CMD_TICK) && ev_live && (rd_data.period != 16'd0);
    assign rd_en     = (state_reg == tskd_pkg::S_RD);
    assign rem_start = (state_reg == tskd_pkg::S_EV) && ev_div;
    assign add_bad   = (id_reg == 8'd0) || (period_reg == 16'd0) || (32'(slot_reg) >= SLOTS);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tskd_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = (tskd_pkg::cmd_t'(s_tuser) == tskd_pkg::CMD_BAD) ?
                                 tskd_pkg::S_FIN : tskd_pkg::S_RD;
                end
            end
            tskd_pkg::S_RD: begin
                state_next = tskd_pkg::S_EV;
            end
            tskd_pkg::S_EV: begin
                if (ev_div) begin
                    state_next = tskd_pkg::S_DIV;
                end else begin
                    state_next = last_slot ? tskd_pkg::S_FIN : tskd_pkg::S_RD;
                end
            end
            tskd_pkg::S_DIV: begin
                if (rem_done) begin
                    if (rem_zero && held_valid_reg) begin
                        state_next = tskd_pkg::S_FIRE;
                    end else begin
                        state_next = last_slot ? tskd_pkg::S_FIN : tskd_pkg::S_RD;
                    end
                end
            end
            tskd_pkg::S_FIRE: begin
                if (out_free) begin
                    state_next = last_slot ? tskd_pkg::S_FIN : tskd_pkg::S_RD;
                end
            end
            tskd_pkg::S_FIN: begin
                if (out_free) begin
                    state_next = tskd_pkg::S_IDLE;
                end
            end
            default: state_next = tskd_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        slot_next       = slot_reg;
        period_next     = period_reg;
        periodic_next   = periodic_reg;
        idx_next        = idx_reg;
        dup_next        = dup_reg;
        used_next       = used_reg;
        hit_next        = hit_reg;
        any_live_next   = any_live_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_id_next    = held_id_reg;
        cand_slot_next  = cand_slot_reg;
        cand_id_next    = cand_id_reg;
        ent_next        = ent_reg;
        cnt_next        = cnt_reg;
        wrap_next       = cfg_we ? cfg_wdata : wrap_reg;
        valid_next      = valid_reg;
        m_valid_next    = m_tready ? 1'b0 : m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;
        wr              = '0;

        unique case (state_reg)
            tskd_pkg::S_IDLE: begin
                if (accept) begin
                    cmd_next        = tskd_pkg::cmd_t'(s_tuser);
                    id_next         = s_tdata[7:0];
                    slot_next       = s_tdata[10:8];
                    period_next     = s_tdata[26:11];
                    periodic_next   = s_tdata[27];
                    idx_next        = '0;
                    dup_next        = 1'b0;
                    used_next       = 1'b0;
                    hit_next        = 1'b0;
                    any_live_next   = 1'b0;
                    held_valid_next = 1'b0;
                    if (tskd_pkg::cmd_t'(s_tuser) == tskd_pkg::CMD_TICK) begin
                        cnt_next = cnt_reg + 16'd1;
                    end
                end
            end
            tskd_pkg::S_RD: begin
            end
            tskd_pkg::S_EV: begin
                ent_next = rd_data;
                if (ev_live) begin
                    any_live_next = 1'b1;
                end
                case (cmd_reg)
                    tskd_pkg::CMD_ADD: begin
                        if (ev_match) begin
                            dup_next = 1'b1;
                        end
                        if (ev_live && (idx_ext == IW'(slot_reg))) begin
                            used_next = 1'b1;
                        end
                    end
                    tskd_pkg::CMD_DEL: begin
                        if (ev_match && !hit_reg) begin
                            hit_next       = 1'b1;
                            wr.en          = 1'b1;
                            wr.addr        = idx_ext;
                            wr.data        = rd_data;
                            wr.data.done   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!ev_div) begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            tskd_pkg::S_DIV: begin
                if (rem_done) begin
                    if (rem_zero) begin
                        if (held_valid_reg) begin
                            cand_slot_next = idx_slot;
                            cand_id_next   = ent_reg.id;
                        end else begin
                            held_valid_next = 1'b1;
                            held_slot_next  = idx_slot;
                            held_id_next    = ent_reg.id;
                            idx_next        = idx_reg + AW'(1);
                        end
                        // A one-shot task retires as soon as its firing is found.
                        if (!ent_reg.periodic) begin
                            wr.en        = 1'b1;
                            wr.addr      = idx_ext;
                            wr.data      = ent_reg;
                            wr.data.done = 1'b1;
                        end
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            tskd_pkg::S_FIRE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = {5'd0, held_id_reg, held_slot_reg};
                    m_user_next    = {1'b1, tskd_pkg::STS_OK};
                    m_last_next    = 1'b0;
                    held_slot_next = cand_slot_reg;
                    held_id_next   = cand_id_reg;
                    idx_next       = idx_reg + AW'(1);
                end
            end
            tskd_pkg::S_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_last_next  = 1'b1;
                    case (cmd_reg)
                        tskd_pkg::CMD_ADD: begin
                            if (add_bad) begin
                                m_user_next = {1'b0, tskd_pkg::STS_INVALID};
                            end else if (dup_reg) begin
                                m_user_next = {1'b0, tskd_pkg::STS_DUP_ID};
                            end else if (used_reg) begin
                                m_user_next = {1'b0, tskd_pkg::STS_SLOT_USED};
                            end else begin
                                m_user_next = {1'b0, tskd_pkg::STS_OK};
                                wr.en       = 1'b1;
                                wr.addr     = IW'(slot_reg);
                                wr.data     = '{done: 1'b0, periodic: periodic_reg,
                                                period: period_reg, id: id_reg};
                                valid_next[AW'(slot_reg)] = 1'b1;
                            end
                        end
                        tskd_pkg::CMD_DEL: begin
                            m_user_next = {1'b0, hit_reg ? tskd_pkg::STS_OK
                                                         : tskd_pkg::STS_NOT_FOUND};
                        end
                        tskd_pkg::CMD_TICK: begin
                            if (held_valid_reg) begin
                                m_data_next = {5'd0, held_id_reg, held_slot_reg};
                                m_user_next = {1'b1, tskd_pkg::STS_OK};
                            end else begin
                                m_user_next = {1'b0, any_live_reg ? tskd_pkg::STS_NONE_FIRE
                                                                  : tskd_pkg::STS_NO_LIVE};
                            end
                            held_valid_next = 1'b0;
                            if (cnt_reg >= wrap_reg) begin
                                cnt_next = '0;
                            end
                        end
                        default: begin
                            m_user_next = {1'b0, tskd_pkg::STS_INVALID};
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tskd_pkg::S_IDLE;
            held_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            wrap_reg       <= tskd_pkg::WRAP_RESET;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            cnt_reg        <= cnt_next;
            wrap_reg       <= wrap_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        slot_reg      <= slot_next;
        period_reg    <= period_next;
        periodic_reg  <= periodic_next;
        idx_reg       <= idx_next;
        dup_reg       <= dup_next;
        used_reg      <= used_next;
        hit_reg       <= hit_next;
        any_live_reg  <= any_live_next;
        held_slot_reg <= held_slot_next;
        held_id_reg   <= held_id_next;
        cand_slot_reg <= cand_slot_next;
        cand_id_reg   <= cand_id_next;
        ent_reg       <= ent_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `TSKD_ASSERT(a_idle_no_held, aclk, aresetn, s_tready |-> !held_valid_reg, "held firing while idle")
    `TSKD_ASSERT(a_rem_in_div, aclk, aresetn, rem_busy |-> (state_reg == tskd_pkg::S_DIV), "remainder unit busy outside divide state")
    `TSKD_ASSERT(a_fire_has_held, aclk, aresetn, (state_reg == tskd_pkg::S_FIRE) |-> held_valid_reg, "fire state without held result")
    `TSKD_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
endmodule
